>>> sv/circle_scanline_span_macros.svh
// Assertion macros shared by the checker of the circle span block.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef CIRCLE_SCANLINE_SPAN_MACROS_SVH
`define CIRCLE_SCANLINE_SPAN_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked across reset.
`define CSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/css_pkg.sv
// Shared types and constants for the circle scanline span block.
// Used by the controller, the datapath and the top level.
package css_pkg;

    localparam int SPAN_W     = 13;  // width of the unsigned size fields
    localparam int RAD_W      = 24;  // radius squared stays below 2**24
    localparam int ROOT_W     = 12;  // floor root of a 24 bit radicand
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int STEP_CNT_W = $clog2(ROOT_STEPS);
    localparam int REM_W      = ROOT_W + 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_WIDTH = 3'd4;

    typedef struct packed {
        logic line_load;   // take the request's line index
        logic prod;        // compute offset, box test and both squares
        logic rad;         // form the radicand and clear the root unit
        logic root_step;   // one two-bit step of the square root
        logic out_load;    // clip the span and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic root_last;   // the current root step is the final one
    } t_dp_status;

endpackage

>>> sv/css_ctrl.sv
// Sequencing state machine and result handshake for the circle span block.
// Depends on css_pkg for the command and status types.
module css_ctrl
    import css_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PROD = 5'b00010,
        ST_RAD  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_CLIP = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The result register may be refilled when empty or when it is taken now.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.line_load = 1'b1;
                    n_state         = ST_PROD;
                end
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_RAD;
            end
            ST_RAD: begin
                o_cmd.rad = 1'b1;
                n_state   = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/css_dp.sv
// Datapath of the circle span block: configuration registers, squares,
// the two-bit-per-step square root, clipping and the result register.
// Depends on css_pkg; driven by css_ctrl through t_dp_cmd.
module css_dp
    import css_pkg::*;
#(
    parameter  int COORD_BITS = 16,
    localparam int CFG_W      = (COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic signed [COORD_BITS-1:0] i_line_index,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    output logic                         o_span_valid,
    output logic [SPAN_W-1:0]            o_span_start,
    output logic signed [COORD_BITS-1:0] o_span_end
);

    // Working width for coordinate sums: room for a coordinate plus two
    // size fields without overflow, and never narrower than a size field.
    localparam int XW = ((COORD_BITS > SPAN_W + 1) ? COORD_BITS : SPAN_W + 1) + 2;

    logic [COORD_BITS-1:0] r_box_left;
    logic [COORD_BITS-1:0] r_box_top;
    logic [SPAN_W-1:0]     r_box_width;
    logic [SPAN_W-1:0]     r_box_height;
    logic [SPAN_W-1:0]     r_disp_width;

    logic [COORD_BITS-1:0] r_line;
    logic                  r_in_box;
    logic [RAD_W-1:0]      r_rr;
    logic [RAD_W-1:0]      r_yy;
    logic                  r_rad_neg;
    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [STEP_CNT_W-1:0] r_cnt;

    logic                  r_span_valid;
    logic [SPAN_W-1:0]     r_span_start;
    logic [COORD_BITS-1:0] r_span_end;

    logic [ROOT_W-1:0]     radius;
    logic [XW-1:0]         line_x;
    logic [XW-1:0]         top_x;
    logic [XW-1:0]         left_x;
    logic [XW-1:0]         dw_x;
    logic [XW-1:0]         d_x;
    logic                  in_box;
    logic [SPAN_W:0]       y_off;
    logic [SPAN_W:0]       y_mag;
    logic [RAD_W+1:0]      rad_diff;
    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic                  take;
    logic [REM_W+1:0]      rem_sub;
    logic [XW-1:0]         s_x;
    logic [XW-1:0]         e_x;
    logic [XW-1:0]         e_clamp;
    logic                  span_ok;

    assign radius = r_box_width[SPAN_W-1:1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_width  <= '0;
            r_box_height <= '0;
            r_disp_width <= SPAN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BOX_LEFT:   r_box_left   <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_TOP:    r_box_top    <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data[SPAN_W-1:0];
                CFG_BOX_HEIGHT: r_box_height <= i_cfg_data[SPAN_W-1:0];
                CFG_DISP_WIDTH: r_disp_width <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign line_x = {{(XW-COORD_BITS){r_line[COORD_BITS-1]}}, r_line};
    assign top_x  = {{(XW-COORD_BITS){r_box_top[COORD_BITS-1]}}, r_box_top};
    assign left_x = {{(XW-COORD_BITS){r_box_left[COORD_BITS-1]}}, r_box_left};
    assign dw_x   = {{(XW-SPAN_W){1'b0}}, r_disp_width};

    // Line position within the box; inside the box it is below the height,
    // so the offset from the centre line fits in a size field plus sign.
    assign d_x    = line_x - top_x;
    assign in_box = !d_x[XW-1] && (d_x < {{(XW-SPAN_W){1'b0}}, r_box_height});
    assign y_off  = {1'b0, d_x[SPAN_W-1:0]} - {2'b00, r_box_height[SPAN_W-1:1]};
    assign y_mag  = y_off[SPAN_W] ? ((SPAN_W+1)'(0) - y_off) : y_off;

    assign rad_diff = {2'b00, r_rr} - {2'b00, r_yy};

    // Restoring square root step: bring down two radicand bits and try
    // subtracting four times the root plus one.
    assign rem_sh  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign take    = (rem_sh >= trial);
    assign rem_sub = take ? (rem_sh - trial) : rem_sh;

    assign o_status.root_last = (r_cnt == STEP_CNT_W'(ROOT_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_load) begin
            r_line <= i_line_index;
        end
        if (i_cmd.prod) begin
            r_in_box <= in_box;
            r_rr     <= RAD_W'(radius) * RAD_W'(radius);
            r_yy     <= RAD_W'(y_mag[ROOT_W-1:0]) * RAD_W'(y_mag[ROOT_W-1:0]);
        end
        if (i_cmd.rad) begin
            r_rad_neg <= rad_diff[RAD_W+1];
            r_rad     <= rad_diff[RAD_W-1:0];
            r_rem     <= '0;
            r_root    <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.root_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= rem_sub[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], take};
            r_cnt  <= r_cnt + STEP_CNT_W'(1);
        end
    end

    // Span ends and clipping against the display.
    assign s_x = left_x + {{(XW-ROOT_W){1'b0}}, radius} - {{(XW-ROOT_W){1'b0}}, r_root};
    assign e_x = left_x + {{(XW-ROOT_W){1'b0}}, radius} + {{(XW-ROOT_W){1'b0}}, r_root};

    assign span_ok = r_in_box && !r_rad_neg && !s_x[XW-1]
                     && ($signed(s_x) <= $signed(dw_x))
                     && !e_x[XW-1]
                     && ($signed(e_x) >= $signed(s_x));

    // An end past the display width is clamped to the width minus one, so to minus one for a zero width.
    assign e_clamp = ($signed(e_x) > $signed(dw_x)) ? (dw_x - XW'(1)) : e_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_span_valid <= span_ok;
            r_span_start <= span_ok ? s_x[SPAN_W-1:0] : '0;
            r_span_end   <= span_ok ? e_clamp[COORD_BITS-1:0] : '0;
        end
    end

    assign o_span_valid = r_span_valid;
    assign o_span_start = r_span_start;
    assign o_span_end   = r_span_end;

endmodule

>>> sv/circle_scanline_span.sv
// Circle scanline span: one result per scanline request, formed in order by the
// squares, the radicand, twelve two-bit root steps and clipping. A new request is
// taken only in the idle state, once the previous result has been loaded, so requests
// do not overlap; a waiting result stalls only the clipping.
// Synchronous active-low reset empties the result register, zeroes the box
// registers and sets the display width to one.
module circle_scanline_span
    import css_pkg::*;
#(
    parameter  int COORD_BITS = 16,
    localparam int CFG_W      = (COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_line_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_span_valid,
    output logic [SPAN_W-1:0]            o_span_start,
    output logic signed [COORD_BITS-1:0] o_span_end
);

    t_dp_cmd    cmd;
    t_dp_status status;

    css_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    css_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_line_index (i_line_index),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_span_valid (o_span_valid),
        .o_span_start (o_span_start),
        .o_span_end   (o_span_end)
    );

endmodule

>>> sv/circle_scanline_span_checker.sv
// Port-level checker for the circle span block and its bind to the top level.
// Depends on css_pkg and circle_scanline_span_macros.svh.
`include "circle_scanline_span_macros.svh"

module circle_scanline_span_checker
    import css_pkg::*;
#(
    parameter  int COORD_BITS = 16,
    localparam int CFG_W      = (COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [CFG_IDX_W-1:0]         i_cfg_index,
    input logic [CFG_W-1:0]             i_cfg_data,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic signed [COORD_BITS-1:0] i_line_index,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_span_valid,
    input logic [SPAN_W-1:0]            o_span_start,
    input logic signed [COORD_BITS-1:0] o_span_end
);

    property p_no_span_zero;
        o_out_valid && !o_span_valid |-> o_span_start == '0 && o_span_end == '0;
    endproperty

    property p_out_hold;
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_span_valid)
            && $stable(o_span_start) && $stable(o_span_end);
    endproperty

    // After reset nothing is pending and a request can be taken at once.
    `CSS_ASSERT_RST(a_reset_clean, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle")

    // A request occupies the block, so the next one is held off.
    `CSS_ASSERT(a_busy_after_req, i_in_valid && !o_in_stall |=> o_in_stall, "not held off")

    // A result with no span carries zero start and end.
    `CSS_ASSERT(a_no_span_zero, p_no_span_zero, "empty span not zeroed")

    // A stalled result stays put.
    `CSS_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

endmodule

bind circle_scanline_span circle_scanline_span_checker #(
    .COORD_BITS (COORD_BITS)
) u_checker (.*);

>>> tb/tb_circle_scanline_span.sv
`timescale 1ns / 1ps
// Self-checking testbench for circle_scanline_span: drives scanline requests and
// register writes, predicts each span and compares every result. Needs css_pkg.
module tb_circle_scanline_span
    import css_pkg::*;
();

    localparam int COORD_W     = 16;
    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 24;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic                      vld;
        logic [SPAN_W-1:0]         first_x;
        logic signed [COORD_W-1:0] last_x;
    } t_span;

    // Holds a copy of the box registers and the spans still owed by the block.
    class span_scoreboard;
        longint box_left, box_top, box_width, box_height, disp_width;
        t_span  spans_due[$];
        int     errors;

        function new();
            box_left   = 0;
            box_top    = 0;
            box_width  = 0;
            box_height = 0;
            disp_width = 1;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
            case (idx)
                CFG_BOX_LEFT:   box_left   = longint'($signed(value));
                CFG_BOX_TOP:    box_top    = longint'($signed(value));
                CFG_BOX_WIDTH:  box_width  = longint'(value[SPAN_W-1:0]);
                CFG_BOX_HEIGHT: box_height = longint'(value[SPAN_W-1:0]);
                CFG_DISP_WIDTH: disp_width = longint'(value[SPAN_W-1:0]);
                default: ;
            endcase
        endfunction

        // Largest r with r*r <= n, built one bit at a time from the top.
        function longint floor_root(longint n);
            longint r, trial;
            r = 0;
            for (int b = 15; b >= 0; b--) begin
                trial = r | (longint'(1) << b);
                if (trial * trial <= n)
                    r = trial;
            end
            return r;
        endfunction

        function void note_request(logic signed [COORD_W-1:0] line);
            longint y_line, radius, offset, radicand, half, x0, x1;
            t_span  due;
            due    = '0;
            y_line = longint'(line);
            radius = box_width / 2;
            if (y_line >= box_top && y_line < box_top + box_height) begin
                offset   = y_line - (box_top + box_height / 2);
                radicand = radius * radius - offset * offset;
                if (radicand >= 0) begin
                    half = floor_root(radicand);
                    x0   = box_left + radius - half;
                    x1   = box_left + radius + half;
                    if (x0 >= 0 && x0 <= disp_width && x1 >= 0 && x1 >= x0) begin
                        // Past the right edge the end is pulled back to the last pixel.
                        if (x1 > disp_width)
                            x1 = disp_width - 1;
                        due.vld     = 1'b1;
                        due.first_x = x0[SPAN_W-1:0];
                        due.last_x  = x1[COORD_W-1:0];
                    end
                end
            end
            spans_due.push_back(due);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic vld, logic [SPAN_W-1:0] first_x,
                          logic signed [COORD_W-1:0] last_x);
            t_span due;
            if (spans_due.size() == 0) begin
                report("span result with no request outstanding");
            end else begin
                due = spans_due.pop_front();
                if (vld !== due.vld)
                    report($sformatf("span_valid %0b, expected %0b", vld, due.vld));
                if (first_x !== due.first_x)
                    report($sformatf("span_start %0d, expected %0d", first_x, due.first_x));
                if (last_x !== due.last_x)
                    report($sformatf("span_end %0d, expected %0d", last_x, due.last_x));
            end
        endtask
    endclass

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = CFG_BOX_LEFT;
    logic [COORD_W-1:0]        i_cfg_data   = '0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_line_index = '0;
    logic                      o_out_valid;
    logic                      i_out_stall  = 1'b0;
    logic                      o_span_valid;
    logic [SPAN_W-1:0]         o_span_start;
    logic signed [COORD_W-1:0] o_span_end;

    span_scoreboard sb = new();

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int cycle_count = 0;

    circle_scanline_span #(.COORD_BITS(COORD_W)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_line_index (i_line_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_span_valid (o_span_valid),
        .o_span_start (o_span_start),
        .o_span_end   (o_span_end)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check each accepted result, then decide the next cycle's stall.
    // A new hold request stalls the output for a long stretch so the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_span_valid, o_span_start, o_span_end);
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_line(input logic signed [COORD_W-1:0] line);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_line_index <= line;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(line);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.spans_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic load_box(input logic signed [COORD_W-1:0] bl, bt,
                            input logic [SPAN_W-1:0] bw, bh, dw);
        put_reg(CFG_BOX_LEFT, bl);
        put_reg(CFG_BOX_TOP, bt);
        put_reg(CFG_BOX_WIDTH, {3'b000, bw});
        put_reg(CFG_BOX_HEIGHT, {3'b000, bh});
        put_reg(CFG_DISP_WIDTH, {3'b000, dw});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int     bw, bh, dw, k;
        longint bl, bt;
        logic signed [COORD_W-1:0] line;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at their reset values: the box is empty, so no line has a span.
        send_line(16'sd0);
        send_line(-16'sd1);
        wait_drain();

        // Circle of radius 20 centred on line 15: extremes of the line field,
        // both box edges and the lines just outside them.
        load_box(16'sd10, -16'sd5, 13'd40, 13'd41, 13'd100);
        send_line(-16'sd32768);
        send_line(16'sd32767);
        send_line(-16'sd6);
        send_line(-16'sd5);
        send_line(16'sd15);
        send_line(16'sd0);
        send_line(16'sd35);
        send_line(16'sd36);
        wait_drain();

        // Box taller than wide: lines far from the centre have a negative radicand.
        load_box(16'sd0, 16'sd0, 13'd10, 13'd30, 13'd100);
        send_line(16'sd0);
        send_line(16'sd15);
        send_line(16'sd29);
        wait_drain();

        // Span starting left of the display, with the end also below zero.
        load_box(-16'sd40, 16'sd0, 13'd20, 13'd20, 13'd50);
        send_line(16'sd10);
        send_line(16'sd0);
        wait_drain();

        // Span starting right of the display.
        load_box(16'sd60, 16'sd0, 13'd20, 13'd20, 13'd50);
        send_line(16'sd10);
        wait_drain();

        // End clamped to the last pixel, once with the start exactly on the width.
        load_box(16'sd40, 16'sd0, 13'd40, 13'd40, 13'd50);
        send_line(16'sd20);
        send_line(16'sd37);
        wait_drain();

        // Zero-width circle on a one-pixel display.
        load_box(16'sd0, 16'sd0, 13'd0, 13'd1, 13'd1);
        send_line(16'sd0);
        send_line(16'sd1);
        wait_drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    bl = 0;      bt = -32768; bw = 8191; bh = 8191; dw = 8191;
                end
                1: begin
                    bl = 32767;  bt = 32767;  bw = 0;    bh = 0;    dw = 1;
                end
                2: begin
                    bl = -32768; bt = 0;      bw = 8191; bh = 8191; dw = 1;
                end
                default: begin
                    dw = ($urandom_range(3) == 0) ? $urandom_range(64, 1)
                                                  : $urandom_range(8191, 1);
                    bw = ($urandom_range(3) == 0) ? $urandom_range(8191)
                                                  : $urandom_range(600);
                    case ($urandom_range(3))
                        0:       bh = $urandom_range(8191);
                        3:       bh = (bw + 4 > 8191) ? 8191 : bw + $urandom_range(4);
                        default: bh = bw;
                    endcase
                    if ($urandom_range(7) == 0)
                        bl = longint'($signed(16'($urandom)));
                    else
                        bl = longint'($urandom_range(dw + bw)) - bw;
                    if ($urandom_range(3) == 0)
                        bt = longint'($signed(16'($urandom)));
                    else
                        bt = longint'($urandom_range(2000)) - 1000;
                end
            endcase

            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 83; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 83; end
                default: begin idle_pct = 28; stall_pct <= 28; end
            endcase
            // Long output hold while requests keep coming, so the input backs up.
            if (ph == 4)
                hold_req <= hold_req + 1;

            load_box(bl[COORD_W-1:0], bt[COORD_W-1:0], bw[SPAN_W-1:0],
                     bh[SPAN_W-1:0], dw[SPAN_W-1:0]);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                k = $urandom_range(99);
                if (bh == 0 || k < 10)
                    line = 16'($urandom);
                else if (k < 18)
                    line = ($urandom_range(1) == 1) ? 16'(bt - 1) : 16'(bt + bh);
                else
                    line = 16'(bt + $urandom_range(bh - 1));
                send_line(line);
            end
            wait_drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
